>>> rtl/pls_pkg.sv
// shared types and codes for the positional list store
package pls_pkg;

  localparam int POS_W  = 8;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NEG   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [POS_W-1:0] position;
    logic [DATA_W-1:0]       item_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] item_out;
    logic [CNT_W-1:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

>>> rtl/positional_list_store_top.sv
// positional list store: ordered list of item handles in a row of shifting cells
//
//  channel | ports                     | direction | payload
//  in      | in_valid in_stall in_data | in        | func, position, item_in
//  out     | out_valid out_stall out_data | out      | status, item_out, entry_count
//
// one item per cycle unless stalled; insert/remove shift cells >= idx when taken
// the result is registered and appears the cycle after the item is accepted
// reset clears the entry count and the output valid; cell contents are left as is
// a stalled result holds its register and stalls the input side in turn
module positional_list_store_top #(
  parameter int CAPACITY   = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pls_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pls_pkg::out_item_t out_data
);
  import pls_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  out_item_t             out_data_r;
  out_item_t             out_data_nxt;

  logic                  accept;
  logic                  neg;
  logic                  full;
  logic                  empty;
  logic [POS_W-1:0]      pos_u;
  logic [POS_W-1:0]      cnt_p;
  logic [POS_W-1:0]      last_p;
  logic [POS_W-1:0]      clamp_p;
  logic [IDX_W-1:0]      idx;
  logic [1:0]            status;
  logic                  fetch;
  cell_ctrl_t            ctrl;
  logic [ITEM_WIDTH-1:0] new_item;
  logic [ITEM_WIDTH-1:0] q   [CAPACITY];
  logic [ITEM_WIDTH-1:0] tap [CAPACITY];
  logic [ITEM_WIDTH-1:0] rd_data;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign neg    = in_data.position[POS_W-1];
  assign full   = (count_r == CW'(CAPACITY));
  assign empty  = (count_r == '0);
  assign pos_u  = in_data.position;
  assign cnt_p  = POS_W'(count_r);
  assign last_p = cnt_p - POS_W'(1);

  // insert clamps to the end, remove and read clamp to the last entry
  always_comb begin
    if (in_data.func == FN_INSERT) begin
      clamp_p = (pos_u > cnt_p) ? cnt_p : pos_u;
    end else begin
      clamp_p = (pos_u > last_p) ? last_p : pos_u;
    end
  end
  assign idx = clamp_p[IDX_W-1:0];

  always_comb begin
    status = ST_OK;
    fetch  = 1'b0;
    case (in_data.func)
      FN_INSERT: begin
        if (neg) begin
          status = ST_NEG;
        end else if (full) begin
          status = ST_FULL;
        end
      end
      FN_REMOVE, FN_READ: begin
        if (neg) begin
          status = ST_NEG;
        end else if (empty) begin
          status = ST_EMPTY;
        end else begin
          fetch = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign ctrl.ins = accept & (in_data.func == FN_INSERT) & (status == ST_OK);
  assign ctrl.rem = accept & (in_data.func == FN_REMOVE) & fetch;
  assign new_item = ITEM_WIDTH'(in_data.item_in);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pls_cell #(
      .INDEX (i),
      .IDX_W (IDX_W),
      .WIDTH (ITEM_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .idx      (idx),
      .new_item (new_item),
      .left_q   (q[(i == 0) ? 0 : i - 1]),
      .right_q  (q[(i == CAPACITY - 1) ? i : i + 1]),
      .q        (q[i]),
      .tap      (tap[i])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | tap[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    out_data_nxt             = out_data_r;
    out_data_nxt.status      = status;
    out_data_nxt.item_out    = fetch ? DATA_W'(rd_data) : '0;
    out_data_nxt.entry_count = CNT_W'(count_nxt);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/pls_cell.sv
// one entry of the list, shifting to or from its neighbors
module pls_cell #(
  parameter int INDEX   = 0,
  parameter int IDX_W   = 4,
  parameter int WIDTH   = 32
) (
  input  logic                clk,
  input  pls_pkg::cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]    idx,
  input  logic [WIDTH-1:0]    new_item,
  input  logic [WIDTH-1:0]    left_q,
  input  logic [WIDTH-1:0]    right_q,
  output logic [WIDTH-1:0]    q,
  output logic [WIDTH-1:0]    tap
);
  import pls_pkg::*;

  logic [WIDTH-1:0] q_r;
  logic [WIDTH-1:0] q_nxt;
  logic             sel;
  logic             above;

  assign sel   = (idx == IDX_W'(INDEX));
  assign above = (IDX_W'(INDEX) > idx);

  always_comb begin
    q_nxt = q_r;
    if (ctrl.ins) begin
      if (sel) begin
        q_nxt = new_item;
      end else if (above) begin
        q_nxt = left_q;
      end
    end else if (ctrl.rem) begin
      if (sel || above) begin
        q_nxt = right_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q   = q_r;
  // read tap, zero unless this cell is the addressed one
  assign tap = sel ? q_r : '0;

endmodule
